/* src/stsq_pkg.sv */
// Package for the tilt stepper sequencer: mode and opcode codes, register
// indexes, coil pattern tables and the control state record.
// No dependencies.
package stsq_pkg;

  // Default width of the step counter
  localparam int CountBitsDefault = 12;

  // Field widths fixed by the interface
  localparam int RawBits   = 12;
  localparam int StepsBits = 12;
  localparam int CfgBits   = 12;
  localparam int AddrBits  = 3;

  // Register reset values
  localparam logic [CfgBits-1:0] HomeOffsetReset = 12'd415;
  localparam logic [CfgBits-1:0] EndStepsReset   = 12'd1024;
  localparam logic [CfgBits-1:0] WrapHighReset   = 12'd4073;
  localparam logic [CfgBits-1:0] WrapLowReset    = 12'd35;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SEEK     = 3'd1,
    MODE_OFFSET   = 3'd2,
    MODE_SCAN     = 3'd3,
    MODE_RSEEK    = 3'd4,
    MODE_ROFFSET  = 3'd5,
    MODE_DONE     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_t;

  typedef enum logic [AddrBits-1:0] {
    REG_HALF_STEP   = 3'd0,
    REG_HOME_OFFSET = 3'd1,
    REG_END_STEPS   = 3'd2,
    REG_WRAP_HIGH   = 3'd3,
    REG_WRAP_LOW    = 3'd4
  } reg_index_t;

  // Control state carried from item to item (step count travels separately)
  typedef struct packed {
    mode_t      mode;
    logic [2:0] phase;
    logic       armed;
    logic       servo;
  } ctrl_t;

  // Configuration register set
  typedef struct packed {
    logic               half_step;
    logic [CfgBits-1:0] home_offset;
    logic [CfgBits-1:0] end_steps;
    logic [CfgBits-1:0] wrap_high;
    logic [CfgBits-1:0] wrap_low;
  } cfg_t;

  // Coil pattern for a phase: two-coil full steps or eight half steps
  function automatic logic [3:0] coil_pattern_f(input logic half, input logic [2:0] phase);
    logic [3:0] pat;
    if (half) begin
      unique case (phase)
        3'd0:    pat = 4'd1;
        3'd1:    pat = 4'd3;
        3'd2:    pat = 4'd2;
        3'd3:    pat = 4'd6;
        3'd4:    pat = 4'd4;
        3'd5:    pat = 4'd12;
        3'd6:    pat = 4'd8;
        default: pat = 4'd9;
      endcase
    end else begin
      unique case (phase[1:0])
        2'd0:    pat = 4'd3;
        2'd1:    pat = 4'd6;
        2'd2:    pat = 4'd12;
        default: pat = 4'd9;
      endcase
    end
    return pat;
  endfunction

endpackage

/* src/stsq_step.sv */
// Next-state and result logic for one request of the tilt stepper sequencer.
// Depends on stsq_pkg.
module stsq_step #(
  parameter int COUNT_BITS = stsq_pkg::CountBitsDefault
) (
  input  stsq_pkg::cfg_t                  cfg,
  input  stsq_pkg::ctrl_t                 ctrl,
  input  logic [COUNT_BITS-1:0]           count,
  input  logic [1:0]                      opcode,
  input  logic                            limit_level,
  input  logic [stsq_pkg::RawBits-1:0]    encoder_raw,
  output stsq_pkg::ctrl_t                 ctrl_next,
  output logic [COUNT_BITS-1:0]           count_next,
  output logic [3:0]                      coil_pattern,
  output logic                            coil_update
);
  import stsq_pkg::*;

  // Compare width covers both the counter and the 12-bit registers
  localparam int CmpBits = (COUNT_BITS > CfgBits) ? COUNT_BITS : CfgBits;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [3:0]            phase_pat;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CmpBits-1:0]    count_wide;
  logic [CmpBits-1:0]    offset_wide;
  logic [CmpBits-1:0]    end_wide;
  logic                  returning;

  assign phase_pat   = coil_pattern_f(cfg.half_step, ctrl.phase);
  assign count_inc   = (count == CountMax) ? count : count + 1'b1;
  assign offset_wide = CmpBits'(cfg.home_offset);
  assign end_wide    = CmpBits'(cfg.end_steps);
  assign returning   = (ctrl.mode == MODE_RSEEK) || (ctrl.mode == MODE_ROFFSET);

  always_comb begin
    ctrl_next    = ctrl;
    count_next   = count;
    coil_pattern = 4'd0;
    coil_update  = 1'b0;
    count_wide   = CmpBits'(count);
    unique case (opcode)
      OP_START: begin
        if (ctrl.mode == MODE_IDLE || ctrl.mode == MODE_DONE) begin
          ctrl_next.mode  = MODE_SEEK;
          ctrl_next.armed = 1'b0;
          ctrl_next.servo = 1'b0;
        end
      end
      OP_TICK: begin
        if (ctrl.mode == MODE_SEEK || ctrl.mode == MODE_RSEEK) begin
          if (limit_level) begin
            // switch open: keep stepping backward
            coil_pattern    = phase_pat;
            coil_update     = 1'b1;
            ctrl_next.phase = ctrl.phase - 3'd1;
          end else begin
            // switch pressed: zero the count and start the offset run, or skip it if the offset is zero
            count_next = '0;
            if (cfg.home_offset == '0) begin
              ctrl_next.mode  = returning ? MODE_DONE : MODE_SCAN;
              ctrl_next.servo = !returning;
            end else begin
              ctrl_next.mode = returning ? MODE_ROFFSET : MODE_OFFSET;
            end
          end
        end else if (ctrl.mode == MODE_OFFSET || ctrl.mode == MODE_ROFFSET) begin
          coil_pattern    = phase_pat;
          coil_update     = 1'b1;
          ctrl_next.phase = ctrl.phase + 3'd1;
          count_next      = count_inc;
          count_wide      = CmpBits'(count_inc);
          if (count_wide >= offset_wide) begin
            ctrl_next.mode  = returning ? MODE_DONE : MODE_SCAN;
            ctrl_next.servo = !returning;
          end
        end
      end
      OP_SAMPLE: begin
        if (ctrl.mode == MODE_SCAN) begin
          if (encoder_raw > cfg.wrap_high) begin
            ctrl_next.armed = 1'b1;
          end else if (ctrl.armed && encoder_raw < cfg.wrap_low) begin
            // armed wrap seen: advance one step
            coil_pattern    = phase_pat;
            coil_update     = 1'b1;
            ctrl_next.phase = ctrl.phase + 3'd1;
            ctrl_next.armed = 1'b0;
            count_next      = count_inc;
            count_wide      = CmpBits'(count_inc);
          end
          if (count_wide >= end_wide) begin
            ctrl_next.mode  = MODE_RSEEK;
            ctrl_next.armed = 1'b0;
          end
        end
      end
      default: begin
        // unknown opcode: hold everything
      end
    endcase
  end

endmodule

/* src/scan_tilt_stepper_sequencer_top.sv */
// Top level of the tilt stepper sequencer: stream ports, configuration
// registers, state and result registers. Depends on stsq_pkg and stsq_step.
//
// Takes one request per clock cycle unless the downstream side stalls, and returns
// exactly one result per request, registered on acceptance. The loop that sets this
// rate is the sequencer state register (mode, coil phase, wrap flag, step
// count), updated in the same cycle a request is accepted. The result
// register stays full while the downstream side stalls; a new request is
// taken whenever the result register is empty or being drained. Start homes
// backward to the limit switch, steps forward by the home offset, then scans
// with the servo on, one step per encoder wrap, until the end count, after
// which it homes again and finishes. Register writes take effect from the
// next request and should be made while no result is pending.
module scan_tilt_stepper_sequencer_top #(
  parameter int COUNT_BITS = stsq_pkg::CountBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // limit_level, encoder_raw[12:1], zero
  input  logic [1:0]                      s_axis_tuser,  // opcode
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // coil_pattern, tilt_steps[15:4],
                                                         // mode[18:16], servo_run[19], zero
  output logic                            m_axis_tuser,  // coil_update
  // configuration write port
  input  logic                            cfg_we,
  input  logic [stsq_pkg::AddrBits-1:0]   cfg_addr,
  input  logic [stsq_pkg::CfgBits-1:0]    cfg_data
);
  import stsq_pkg::*;

  cfg_t                  cfg;
  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [3:0]            pat_next;
  logic                  upd_next;
  logic                  in_fire;

  // result register
  logic [3:0]            coil_pattern;
  logic                  coil_update;
  logic [StepsBits-1:0]  tilt_steps;
  mode_t                 mode;
  logic                  servo_run;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_step   <= 1'b0;
      cfg.home_offset <= HomeOffsetReset;
      cfg.end_steps   <= EndStepsReset;
      cfg.wrap_high   <= WrapHighReset;
      cfg.wrap_low    <= WrapLowReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HALF_STEP:   cfg.half_step   <= cfg_data[0];
        REG_HOME_OFFSET: cfg.home_offset <= cfg_data;
        REG_END_STEPS:   cfg.end_steps   <= cfg_data;
        REG_WRAP_HIGH:   cfg.wrap_high   <= cfg_data;
        REG_WRAP_LOW:    cfg.wrap_low    <= cfg_data;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  stsq_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg          (cfg),
    .ctrl         (ctrl),
    .count        (count),
    .opcode       (s_axis_tuser),
    .limit_level  (s_axis_tdata[0]),
    .encoder_raw  (s_axis_tdata[12:1]),
    .ctrl_next    (ctrl_next),
    .count_next   (count_next),
    .coil_pattern (pat_next),
    .coil_update  (upd_next)
  );

  // Advance sequencer state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode  <= MODE_IDLE;
      ctrl.phase <= 3'd0;
      ctrl.armed <= 1'b0;
      ctrl.servo <= 1'b0;
      count      <= '0;
    end else if (in_fire) begin
      ctrl  <= ctrl_next;
      count <= count_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      coil_pattern <= pat_next;
      coil_update  <= upd_next;
      tilt_steps   <= StepsBits'(count_next);
      mode         <= ctrl_next.mode;
      servo_run    <= ctrl_next.servo;
    end
  end

  assign m_axis_tdata = {4'd0, servo_run, mode, tilt_steps, coil_pattern};
  assign m_axis_tuser = coil_update;

endmodule

/* src/stsq_checker.sv */
// Port-level checks for the tilt stepper sequencer, bound to the top level.
// Depends on stsq_pkg and scan_tilt_stepper_sequencer_top.
module stsq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [23:0]                     m_axis_tdata,
  input logic                            m_axis_tuser
);
  import stsq_pkg::*;

  logic [2:0] out_mode;
  assign out_mode = m_axis_tdata[18:16];

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A result with no coil update carries a zero pattern, an update a nonzero one
  a_pattern_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tuser == 1'b0) == (m_axis_tdata[3:0] == 4'd0)))
    else $error("coil pattern disagrees with update flag");

  // Servo runs only between end of homing and end of return homing
  a_servo_mode: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[19]) |->
      (out_mode == MODE_SCAN || out_mode == MODE_RSEEK || out_mode == MODE_ROFFSET))
    else $error("servo on outside scan or return");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind scan_tilt_stepper_sequencer_top stsq_checker u_stsq_checker (.*);

/* tb/testbench.sv */
// Self-checking bench for scan_tilt_stepper_sequencer_top: a clocked driver and
// monitor with random idling, a built-in sequencer predictor and config phases.
// Depends on stsq_pkg and the RTL of the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stsq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [StepsBits-1:0] COUNT_MAX = 12'hFFF;
  localparam logic [3:0] FULL_COILS [0:7] = '{4'd3, 4'd6, 4'd12, 4'd9, 4'd3, 4'd6, 4'd12, 4'd9};
  localparam logic [3:0] HALF_COILS [0:7] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

  typedef struct packed {
    logic [1:0]  op;
    logic        limit;
    logic [11:0] raw;
  } drive_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  phase;
    logic        armed;
    logic [11:0] count;
    logic        servo;
  } seq_state_t;

  typedef struct packed {
    logic [3:0]  pat;
    logic        upd;
    logic [11:0] steps;
    mode_t       mode;
    logic        servo;
  } coil_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [AddrBits-1:0] cfg_addr = '0;
  logic [CfgBits-1:0] cfg_data = '0;

  drive_item_t  cmd_backlog[$];
  coil_result_t results_due[$];
  drive_item_t  on_bus;
  seq_state_t   live_st;
  seq_state_t   plan_st;
  cfg_t         cfg;
  int fault_count = 0;
  int wf_count = 0;
  int send_gap = 0;
  int hold_left = 0;
  logic tx_busy = 1'b0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  scan_tilt_stepper_sequencer_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coil drive for a phase under the current stepping mode
  function automatic logic [3:0] coil_at(input logic half, input logic [2:0] ph);
    return half ? HALF_COILS[ph] : FULL_COILS[ph];
  endfunction

  // Drive one forward step: pattern, phase up, count up with saturation
  function automatic logic [3:0] forward_step(inout seq_state_t st, input cfg_t c);
    logic [3:0] pat;
    pat = coil_at(c.half_step, st.phase);
    st.phase = st.phase + 3'd1;
    if (st.count != COUNT_MAX) st.count = st.count + 12'd1;
    return pat;
  endfunction

  // Leave the offset: scan with servo on, or done with servo off on return
  function automatic void land_home(inout seq_state_t st, input logic returning);
    st.mode = returning ? MODE_DONE : MODE_SCAN;
    st.servo = !returning;
  endfunction

  // Apply one request to a sequencer state and return its result
  function automatic coil_result_t advance_sequencer(inout seq_state_t st, input cfg_t c,
                                                     input drive_item_t it);
    coil_result_t r;
    logic returning;
    r = '0;
    case (it.op)
      OP_START: begin
        if (st.mode == MODE_IDLE || st.mode == MODE_DONE) begin
          st.mode = MODE_SEEK;
          st.armed = 1'b0;
          st.servo = 1'b0;
        end
      end
      OP_TICK: begin
        if (st.mode == MODE_SEEK || st.mode == MODE_RSEEK) begin
          returning = (st.mode == MODE_RSEEK);
          if (it.limit) begin
            r.pat = coil_at(c.half_step, st.phase);
            r.upd = 1'b1;
            st.phase = st.phase - 3'd1;
          end else begin
            st.count = '0;
            if (c.home_offset == '0) land_home(st, returning);
            else st.mode = returning ? MODE_ROFFSET : MODE_OFFSET;
          end
        end else if (st.mode == MODE_OFFSET || st.mode == MODE_ROFFSET) begin
          returning = (st.mode == MODE_ROFFSET);
          r.pat = forward_step(st, c);
          r.upd = 1'b1;
          if (st.count >= c.home_offset) land_home(st, returning);
        end
      end
      OP_SAMPLE: begin
        if (st.mode == MODE_SCAN) begin
          if (it.raw > c.wrap_high) begin
            st.armed = 1'b1;
          end else if (st.armed && it.raw < c.wrap_low) begin
            r.pat = forward_step(st, c);
            r.upd = 1'b1;
            st.armed = 1'b0;
          end
          if (st.count >= c.end_steps) begin
            st.mode = MODE_RSEEK;
            st.armed = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.steps = st.count;
    r.mode = st.mode;
    r.servo = st.servo;
    return r;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Present requests from the backlog, predict each one at acceptance
  always @(posedge clk) begin : drive_requests
    coil_result_t due;
    logic present;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      present = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        due = advance_sequencer(live_st, cfg, on_bus);
        results_due.push_back(due);
        present = 1'b0;
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          on_bus = cmd_backlog.pop_front();
          s_axis_tdata <= {3'b000, on_bus.raw, on_bus.limit};
          s_axis_tuser <= on_bus.op;
          present = 1'b1;
          send_gap = tx_quiet ? 0 : draw_gap();
        end
      end
      tx_busy = present;
      s_axis_tvalid <= present;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_quiet && $urandom_range(9, 0) < 3) hold_left = draw_gap();
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    coil_result_t want;
    coil_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pat = m_axis_tdata[3:0];
      got.upd = m_axis_tuser;
      got.steps = m_axis_tdata[15:4];
      got.mode = mode_t'(m_axis_tdata[18:16]);
      got.servo = m_axis_tdata[19];
      if (results_due.size() == 0) begin
        if (fault_count < 10) $display("unexpected result: %h", m_axis_tdata);
        fault_count++;
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          if (fault_count < 10) begin
            $display("mismatch: exp pat=%0d upd=%0d steps=%0d mode=%0d servo=%0d",
                     want.pat, want.upd, want.steps, want.mode, want.servo);
            $display("          got pat=%0d upd=%0d steps=%0d mode=%0d servo=%0d",
                     got.pat, got.upd, got.steps, got.mode, got.servo);
          end
          fault_count++;
        end
      end
    end
  end

  // Queue one request and track the state it leaves behind
  task automatic queue_item(input logic [1:0] op, input logic limit, input logic [11:0] raw);
    drive_item_t it;
    it.op = op;
    it.limit = limit;
    it.raw = raw;
    void'(advance_sequencer(plan_st, cfg, it));
    cmd_backlog.push_back(it);
  endtask

  // Hold until every request is accepted and every result has come back
  task automatic drain();
    while (cmd_backlog.size() != 0 || tx_busy || results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CfgBits-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write the whole register set while the block is quiet
  task automatic load_config(input cfg_t c);
    drain();
    write_reg(REG_HALF_STEP, {11'd0, c.half_step});
    write_reg(REG_HOME_OFFSET, c.home_offset);
    write_reg(REG_END_STEPS, c.end_steps);
    write_reg(REG_WRAP_HIGH, c.wrap_high);
    write_reg(REG_WRAP_LOW, c.wrap_low);
    cfg = c;
  endtask

  // Random well-formed homing and scanning runs with some noise mixed in
  task automatic run_session(input int cap, input int runs);
    int sent;
    int landed;
    mode_t prev;
    logic [11:0] raw;
    sent = 0;
    landed = 0;
    while (sent < cap && landed < runs) begin
      prev = plan_st.mode;
      if ($urandom_range(9, 0) == 0) begin
        queue_item(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                   12'($urandom_range(4095, 0)));
      end else begin
        wf_count++;
        case (plan_st.mode)
          MODE_IDLE, MODE_DONE:
            queue_item(OP_START, 1'($urandom_range(1, 0)), 12'($urandom_range(4095, 0)));
          MODE_SEEK, MODE_RSEEK:
            queue_item(OP_TICK, $urandom_range(5, 0) != 0, 12'($urandom_range(4095, 0)));
          MODE_OFFSET, MODE_ROFFSET:
            queue_item(OP_TICK, 1'($urandom_range(1, 0)), 12'($urandom_range(4095, 0)));
          default: begin
            if (!plan_st.armed && cfg.wrap_high != 12'hFFF)
              raw = 12'($urandom_range(4095, int'(cfg.wrap_high) + 1));
            else if (plan_st.armed && cfg.wrap_low != 12'd0)
              raw = 12'($urandom_range(int'(cfg.wrap_low) - 1, 0));
            else
              raw = 12'($urandom_range(4095, 0));
            queue_item(OP_SAMPLE, 1'($urandom_range(1, 0)), raw);
          end
        endcase
      end
      if (plan_st.mode == MODE_DONE && prev != MODE_DONE) landed++;
      sent++;
    end
  endtask

  initial begin
    cfg_t c;
    cfg.half_step = 1'b0;
    cfg.home_offset = HomeOffsetReset;
    cfg.end_steps = EndStepsReset;
    cfg.wrap_high = WrapHighReset;
    cfg.wrap_low = WrapLowReset;
    live_st = '0;
    plan_st = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Ignored requests while idle, start, backward seek, limit hit, offset steps
    queue_item(OP_UNUSED, 1'b1, 12'hFFF);
    queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_SAMPLE, 1'b0, 12'hFFF);
    queue_item(OP_START, 1'b0, 12'd0);
    queue_item(OP_START, 1'b1, 12'hFFF);
    queue_item(OP_SAMPLE, 1'b1, 12'd0);
    repeat (3) queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_TICK, 1'b0, 12'd0);
    queue_item(OP_TICK, 1'b0, 12'hFFF);
    queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_UNUSED, 1'b0, 12'd0);
    queue_item(OP_START, 1'b0, 12'd0);
    queue_item(OP_SAMPLE, 1'b0, 12'hFFF);

    // Switch to half steps mid-offset, then arm, wrap, end scan and home again
    c.half_step = 1'b1;
    c.home_offset = 12'd2;
    c.end_steps = 12'd5;
    c.wrap_high = 12'd4094;
    c.wrap_low = 12'd1;
    load_config(c);
    queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_SAMPLE, 1'b0, 12'hFFF);
    queue_item(OP_SAMPLE, 1'b0, 12'd0);
    queue_item(OP_SAMPLE, 1'b0, 12'd4094);
    queue_item(OP_SAMPLE, 1'b0, 12'hFFF);
    queue_item(OP_SAMPLE, 1'b0, 12'd0);
    queue_item(OP_TICK, 1'b0, 12'd0);
    queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_TICK, 1'b1, 12'd0);
    queue_item(OP_START, 1'b0, 12'd0);

    // Zero offset goes straight to scan; end of one step
    c = '{half_step: 1'b0, home_offset: 12'd0, end_steps: 12'd1,
          wrap_high: 12'd2000, wrap_low: 12'd2000};
    load_config(c);
    run_session(300, 2);

    // Widest thresholds: any nonzero sample arms, so only a zero sample steps
    c = '{half_step: 1'b1, home_offset: 12'd5, end_steps: 12'd20,
          wrap_high: 12'd0, wrap_low: 12'hFFF};
    load_config(c);
    run_session(400, 2);

    // Unreachable thresholds: scan ends on its first sample
    c = '{half_step: 1'b0, home_offset: 12'd10, end_steps: 12'd5,
          wrap_high: 12'hFFF, wrap_low: 12'd0};
    load_config(c);
    run_session(300, 2);

    // Largest offset and end count, cut short inside the offset, no idling
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    c = '{half_step: 1'b1, home_offset: 12'hFFF, end_steps: 12'hFFF,
          wrap_high: 12'd3000, wrap_low: 12'd100};
    load_config(c);
    run_session(250, 1);

    // Random settings, mostly small sizes
    wf_count = 0;
    while (wf_count < 900) begin
      c.half_step = 1'($urandom_range(1, 0));
      c.home_offset = 12'($urandom_range(12, 0));
      c.end_steps = 12'($urandom_range(30, 1));
      if ($urandom_range(4, 0) == 0) begin
        c.wrap_high = 12'($urandom_range(4095, 0));
        c.wrap_low = 12'($urandom_range(4095, 0));
      end else begin
        c.wrap_high = 12'($urandom_range(4095, 3000));
        c.wrap_low = 12'($urandom_range(1000, 0));
      end
      tx_quiet = ($urandom_range(3, 0) == 0);
      rx_quiet = ($urandom_range(3, 0) == 0);
      load_config(c);
      run_session(300, 2);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/stsq_pkg.sv
src/stsq_step.sv
src/scan_tilt_stepper_sequencer_top.sv
src/stsq_checker.sv
tb/testbench.sv
